[sv/bsfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_pkg
// Shared constants, types and the CRC-8 byte step of the battery status
// frame receiver.
// ----------------------------------------------------------------------------
package bsfr_pkg;

  localparam int unsigned FRAME_BYTES = 36;
  localparam int unsigned CNT_W       = $clog2(FRAME_BYTES);

  localparam logic [7:0] CRC_POLY = 8'h8C;
  localparam logic [7:0] CRC_INIT = 8'h00;

  // byte offsets inside a frame
  localparam logic [CNT_W-1:0] OFS_CHARGE    = CNT_W'(5);
  localparam logic [CNT_W-1:0] OFS_TEMP_LO   = CNT_W'(7);
  localparam logic [CNT_W-1:0] OFS_TEMP_HI   = CNT_W'(10);
  localparam logic [CNT_W-1:0] OFS_VOLT_L    = CNT_W'(21);
  localparam logic [CNT_W-1:0] OFS_VOLT_H    = CNT_W'(22);
  localparam logic [CNT_W-1:0] OFS_CURR_L    = CNT_W'(25);
  localparam logic [CNT_W-1:0] OFS_CURR_H    = CNT_W'(26);
  localparam logic [CNT_W-1:0] OFS_CELL_HI_L = CNT_W'(29);
  localparam logic [CNT_W-1:0] OFS_CELL_HI_H = CNT_W'(30);
  localparam logic [CNT_W-1:0] OFS_CELL_LO_L = CNT_W'(31);
  localparam logic [CNT_W-1:0] OFS_CELL_LO_H = CNT_W'(32);
  localparam logic [CNT_W-1:0] OFS_CRC       = CNT_W'(FRAME_BYTES - 1);

  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  typedef struct packed {
    logic               frame_good;
    logic [7:0]         charge_percent;
    logic [15:0]        pack_millivolts;
    logic signed [15:0] current_milliamps;
    logic [15:0]        cell_high_mv;
    logic [15:0]        cell_low_mv;
    logic [7:0]         temp_max;
    logic [7:0]         temp_min;
  } bsfr_result_t;

  // reflected CRC-8, one byte, LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] crc;
    logic       fb;
    crc = crc_in;
    for (int i = 0; i < 8; i++) begin
      fb  = crc[0] ^ data[i];
      crc = {1'b0, crc[7:1]};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

[sv/battery_status_frame_receiver_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// battery_status_frame_receiver_top
// Gathers fixed-length battery status frames, checks CRC-8 and reports fields.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_stall_o is low. Each data item taken
// with no good frame held updates the running CRC, the byte count and the
// field captures in the same cycle; a frame's last byte produces one result.
// A two-entry output stage (output register plus skid register)
// decouples the sides: in_stall_o rises only while the skid register holds a
// result behind a stalled output. After a good frame data items are dropped
// until a restart item; a bad frame result has all fields zero.
module battery_status_frame_receiver_top
  import bsfr_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               kind_i,
  input  wire logic [7:0]         byte_value_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic                    frame_good_o,
  output logic [7:0]              charge_percent_o,
  output logic [15:0]             pack_millivolts_o,
  output logic signed [15:0]      current_milliamps_o,
  output logic [15:0]             cell_high_mv_o,
  output logic [15:0]             cell_low_mv_o,
  output logic [7:0]              temp_max_o,
  output logic [7:0]              temp_min_o
);

  logic [7:0]       crc_q, crc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             held_q, held_d;
  logic [7:0]       charge_q, charge_d;
  logic [15:0]      volt_q, volt_d;
  logic [15:0]      curr_q, curr_d;
  logic [15:0]      cell_hi_q, cell_hi_d;
  logic [15:0]      cell_lo_q, cell_lo_d;
  logic [7:0]       tmax_q, tmax_d;
  logic [7:0]       tmin_q, tmin_d;

  bsfr_result_t     res_d, out_q, skid_q;
  logic             res_vld;
  logic             out_vld_q, skid_vld_q;
  logic             in_fire, out_fire, good;

  assign in_stall_o = skid_vld_q;
  assign in_fire    = in_valid_i & ~skid_vld_q;
  assign out_fire   = out_vld_q & ~out_stall_i;
  assign good       = (byte_value_i == crc_q);

  always_comb begin
    crc_d     = crc_q;
    cnt_d     = cnt_q;
    held_d    = held_q;
    charge_d  = charge_q;
    volt_d    = volt_q;
    curr_d    = curr_q;
    cell_hi_d = cell_hi_q;
    cell_lo_d = cell_lo_q;
    tmax_d    = tmax_q;
    tmin_d    = tmin_q;
    res_vld   = 1'b0;
    res_d     = '0;
    if (in_fire) begin
      if (kind_i == KIND_RESTART) begin
        crc_d  = CRC_INIT;
        cnt_d  = '0;
        tmax_d = 8'h00;
        tmin_d = 8'hFF;
        held_d = 1'b0;
      end else if (!held_q) begin
        if (cnt_q >= OFS_CRC) begin
          res_vld = 1'b1;
          if (good) begin
            res_d.frame_good        = 1'b1;
            res_d.charge_percent    = charge_q;
            res_d.pack_millivolts   = volt_q;
            res_d.current_milliamps = curr_q;
            res_d.cell_high_mv      = cell_hi_q;
            res_d.cell_low_mv       = cell_lo_q;
            res_d.temp_max          = tmax_q;
            res_d.temp_min          = tmin_q;
            held_d                  = 1'b1;
          end
          crc_d  = CRC_INIT;
          cnt_d  = '0;
          tmax_d = 8'h00;
          tmin_d = 8'hFF;
        end else begin
          if (cnt_q == OFS_CHARGE)    charge_d        = byte_value_i;
          if (cnt_q == OFS_VOLT_L)    volt_d[7:0]     = byte_value_i;
          if (cnt_q == OFS_VOLT_H)    volt_d[15:8]    = byte_value_i;
          if (cnt_q == OFS_CURR_L)    curr_d[7:0]     = byte_value_i;
          if (cnt_q == OFS_CURR_H)    curr_d[15:8]    = byte_value_i;
          if (cnt_q == OFS_CELL_HI_L) cell_hi_d[7:0]  = byte_value_i;
          if (cnt_q == OFS_CELL_HI_H) cell_hi_d[15:8] = byte_value_i;
          if (cnt_q == OFS_CELL_LO_L) cell_lo_d[7:0]  = byte_value_i;
          if (cnt_q == OFS_CELL_LO_H) cell_lo_d[15:8] = byte_value_i;
          if (cnt_q >= OFS_TEMP_LO && cnt_q <= OFS_TEMP_HI) begin
            if (byte_value_i > tmax_q) tmax_d = byte_value_i;
            if (byte_value_i < tmin_q) tmin_d = byte_value_i;
          end
          crc_d = crc8_byte(crc_q, byte_value_i);
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q     <= CRC_INIT;
      cnt_q     <= '0;
      held_q    <= 1'b0;
      charge_q  <= '0;
      volt_q    <= '0;
      curr_q    <= '0;
      cell_hi_q <= '0;
      cell_lo_q <= '0;
      tmax_q    <= 8'h00;
      tmin_q    <= 8'hFF;
    end else begin
      crc_q     <= crc_d;
      cnt_q     <= cnt_d;
      held_q    <= held_d;
      charge_q  <= charge_d;
      volt_q    <= volt_d;
      curr_q    <= curr_d;
      cell_hi_q <= cell_hi_d;
      cell_lo_q <= cell_lo_d;
      tmax_q    <= tmax_d;
      tmin_q    <= tmin_d;
    end
  end

  // output register with skid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      if (skid_vld_q) begin
        if (out_fire) begin
          out_vld_q  <= 1'b1;
          skid_vld_q <= 1'b0;
        end
      end else if (res_vld) begin
        if (!out_vld_q || out_fire) begin
          out_vld_q <= 1'b1;
        end else begin
          skid_vld_q <= 1'b1;
        end
      end else if (out_fire) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (res_vld) begin
      if (!out_vld_q || out_fire) begin
        out_q <= res_d;
      end else begin
        skid_q <= res_d;
      end
    end
  end

  assign out_valid_o         = out_vld_q;
  assign frame_good_o        = out_q.frame_good;
  assign charge_percent_o    = out_q.charge_percent;
  assign pack_millivolts_o   = out_q.pack_millivolts;
  assign current_milliamps_o = out_q.current_milliamps;
  assign cell_high_mv_o      = out_q.cell_high_mv;
  assign cell_low_mv_o       = out_q.cell_low_mv;
  assign temp_max_o          = out_q.temp_max;
  assign temp_min_o          = out_q.temp_min;

endmodule
`default_nettype wire

[sv/bsfr_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bsfr_checker
// Port-level checks on the battery status frame receiver.
// ----------------------------------------------------------------------------
module bsfr_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire logic               frame_good_o,
  input wire logic [7:0]         charge_percent_o,
  input wire logic [15:0]        pack_millivolts_o,
  input wire logic signed [15:0] current_milliamps_o,
  input wire logic [15:0]        cell_high_mv_o,
  input wire logic [15:0]        cell_low_mv_o,
  input wire logic [7:0]         temp_max_o,
  input wire logic [7:0]         temp_min_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(frame_good_o) && $stable(pack_millivolts_o)
      && $stable(current_milliamps_o) && $stable(temp_min_o))
    else $error("stalled result changed");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_good_o |-> charge_percent_o == 8'd0
      && pack_millivolts_o == 16'd0 && current_milliamps_o == 16'sd0
      && cell_high_mv_o == 16'd0 && cell_low_mv_o == 16'd0
      && temp_max_o == 8'd0 && temp_min_o == 8'd0)
    else $error("bad frame result carries data");

  a_temp_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_good_o |-> temp_max_o >= temp_min_o)
    else $error("temperature max below min");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

endmodule

bind battery_status_frame_receiver_top bsfr_checker u_bsfr_checker (.*);
`default_nettype wire
